/* hw/rtl/bcg_pkg.sv */
// Shared constants for the bilinear corner gradient core.
`timescale 1ns / 1ps
package bcg_pkg;

  // Default for the largest image side supported.
  localparam int unsigned MAX_DIM_DEF = 4096;

  // Field widths of the request and result items.
  localparam int unsigned COORD_W = 12;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned DIM_W   = 13;

  // Configuration bus widths.
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_TOP_LEFT     = 3'd0;
  localparam logic [2:0] REG_TOP_RIGHT    = 3'd1;
  localparam logic [2:0] REG_BOTTOM_LEFT  = 3'd2;
  localparam logic [2:0] REG_BOTTOM_RIGHT = 3'd3;
  localparam logic [2:0] REG_WIDTH        = 3'd4;
  localparam logic [2:0] REG_HEIGHT       = 3'd5;

  // Reset image size.
  localparam logic [DIM_W-1:0] DIM_RESET = 13'd640;

endpackage

/* hw/rtl/bilinear_corner_gradient_core.sv */
// Bilinear corner gradient pixel generator: datapath, divider pipeline and registers.
// Throughput: one pixel per cycle unless the output stalls; three multiply stages
// feed eight restoring division stages, one quotient bit each, and the whole
// pipeline stalls together.
// Reset: asynchronous, active low; clears all valid bits, colours to zero and the
// image size to 640 by 640.
`timescale 1ns / 1ps
module bilinear_corner_gradient_core #(
  parameter int unsigned MAX_DIM = bcg_pkg::MAX_DIM_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request channel.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // column [11:0], row [23:12]
  input  logic [2*bcg_pkg::COORD_W-1:0] s_axis_tdata,
  // Result channel.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  output logic [3*bcg_pkg::CHAN_W-1:0] m_axis_tdata,
  // out_of_range [0]
  output logic                         m_axis_tuser,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcg_pkg::ADDR_W-1:0]   paddr,
  input  logic [bcg_pkg::DATA_W-1:0]   pwdata,
  output logic [bcg_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int unsigned DW   = $clog2(MAX_DIM + 1);
  localparam int unsigned CW   = (DW > bcg_pkg::COORD_W) ? DW : bcg_pkg::COORD_W;
  localparam int unsigned WW   = DW + 1;
  localparam int unsigned AW   = WW + 9;
  localparam int unsigned DENW = 2 * DW + 2;
  localparam int unsigned NW   = 2 * DW + 12;
  localparam int unsigned NSTG = 8;

  // Configuration registers.
  logic [bcg_pkg::COLOR_W-1:0] tl_q, tr_q, bl_q, br_q;
  logic [bcg_pkg::DIM_W-1:0]   width_q, height_q;
  logic [2:0]                  reg_idx;
  logic                        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tl_q     <= '0;
      tr_q     <= '0;
      bl_q     <= '0;
      br_q     <= '0;
      width_q  <= bcg_pkg::DIM_RESET;
      height_q <= bcg_pkg::DIM_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        bcg_pkg::REG_TOP_LEFT:     tl_q     <= pwdata[bcg_pkg::COLOR_W-1:0];
        bcg_pkg::REG_TOP_RIGHT:    tr_q     <= pwdata[bcg_pkg::COLOR_W-1:0];
        bcg_pkg::REG_BOTTOM_LEFT:  bl_q     <= pwdata[bcg_pkg::COLOR_W-1:0];
        bcg_pkg::REG_BOTTOM_RIGHT: br_q     <= pwdata[bcg_pkg::COLOR_W-1:0];
        bcg_pkg::REG_WIDTH:        width_q  <= pwdata[bcg_pkg::DIM_W-1:0];
        bcg_pkg::REG_HEIGHT:       height_q <= pwdata[bcg_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      bcg_pkg::REG_TOP_LEFT:     prdata = 32'(tl_q);
      bcg_pkg::REG_TOP_RIGHT:    prdata = 32'(tr_q);
      bcg_pkg::REG_BOTTOM_LEFT:  prdata = 32'(bl_q);
      bcg_pkg::REG_BOTTOM_RIGHT: prdata = 32'(br_q);
      bcg_pkg::REG_WIDTH:        prdata = 32'(width_q);
      bcg_pkg::REG_HEIGHT:       prdata = 32'(height_q);
      default:                   prdata = '0;
    endcase
  end

  // Whole pipeline moves when the output register is empty or being taken.
  logic adv;
  logic dv_q [NSTG];
  assign adv           = !dv_q[NSTG-1] || m_axis_tready;
  assign s_axis_tready = adv;

  // Clamp the image size to 1..MAX_DIM.
  logic [DW-1:0] wc, hc;
  always_comb begin
    if (width_q == '0) wc = DW'(1);
    else if (32'(width_q) > 32'(MAX_DIM)) wc = DW'(MAX_DIM);
    else wc = DW'(width_q);
    if (height_q == '0) hc = DW'(1);
    else if (32'(height_q) > 32'(MAX_DIM)) hc = DW'(MAX_DIM);
    else hc = DW'(height_q);
  end

  // Stage 1: range check, edge weights and denominator.
  logic [CW-1:0]   xe, ye, we, he;
  logic [CW+1:0]   lft_t, top_t, rgt_t, bot_t;
  logic            oor_c;
  logic            v1_q, oor1_q;
  logic [WW-1:0]   l1_q, r1_q, t1_q, b1_q;
  logic [DENW-1:0] den1_q;

  assign xe    = CW'(s_axis_tdata[bcg_pkg::COORD_W-1:0]);
  assign ye    = CW'(s_axis_tdata[2*bcg_pkg::COORD_W-1:bcg_pkg::COORD_W]);
  assign we    = CW'(wc);
  assign he    = CW'(hc);
  assign oor_c = (xe >= we) || (ye >= he);
  assign lft_t = {1'b0, we, 1'b0} - {1'b0, xe, 1'b0} - (CW+2)'(1);
  assign rgt_t = {1'b0, xe, 1'b1};
  assign top_t = {1'b0, he, 1'b0} - {1'b0, ye, 1'b0} - (CW+2)'(1);
  assign bot_t = {1'b0, ye, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= s_axis_tvalid;
  end

  // Outside the image all weights go to zero so the quotient is zero.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      oor1_q <= oor_c;
      l1_q   <= oor_c ? '0 : lft_t[WW-1:0];
      r1_q   <= oor_c ? '0 : rgt_t[WW-1:0];
      t1_q   <= oor_c ? '0 : top_t[WW-1:0];
      b1_q   <= oor_c ? '0 : bot_t[WW-1:0];
      den1_q <= {(DENW-2)'(wc) * (DENW-2)'(hc), 2'b00};
    end
  end

  // Stage 2: horizontal blend per channel for the top and bottom edges.
  logic            v2_q, oor2_q;
  logic [WW-1:0]   t2_q, b2_q;
  logic [DENW-1:0] den2_q;
  logic [AW-1:0]   at2_q [3];
  logic [AW-1:0]   ab2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      oor2_q <= oor1_q;
      t2_q   <= t1_q;
      b2_q   <= b1_q;
      den2_q <= den1_q;
      for (int c = 0; c < 3; c++) begin
        at2_q[c] <= AW'(tl_q[16-8*c +: 8]) * AW'(l1_q) + AW'(tr_q[16-8*c +: 8]) * AW'(r1_q);
        ab2_q[c] <= AW'(bl_q[16-8*c +: 8]) * AW'(l1_q) + AW'(br_q[16-8*c +: 8]) * AW'(r1_q);
      end
    end
  end

  // Stage 3: vertical blend gives the numerator per channel.
  logic            v3_q, oor3_q;
  logic [DENW-1:0] den3_q;
  logic [NW-1:0]   num3_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      oor3_q <= oor2_q;
      den3_q <= den2_q;
      for (int c = 0; c < 3; c++) begin
        num3_q[c] <= NW'(t2_q) * NW'(at2_q[c]) + NW'(b2_q) * NW'(ab2_q[c]);
      end
    end
  end

  // Stages 4 to 11: restoring division, one quotient bit per stage, MSB first.
  logic [NW-1:0]          drem_q [NSTG][3];
  logic [7:0]             dq_q   [NSTG][3];
  logic [DENW-1:0]        dden_q [NSTG];
  logic                   door_q [NSTG];
  logic [NW-1:0]          irem   [NSTG][3];
  logic [7:0]             iq     [NSTG][3];
  logic [DENW-1:0]        iden   [NSTG];
  logic                   ioor   [NSTG];
  logic                   iv     [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_div
    localparam int unsigned B = NSTG - 1 - k;
    logic [NW-1:0] dsh;

    if (k == 0) begin : g_first
      assign iden[k] = den3_q;
      assign ioor[k] = oor3_q;
      assign iv[k]   = v3_q;
      for (genvar c = 0; c < 3; c++) begin : g_ch
        assign irem[k][c] = num3_q[c];
        assign iq[k][c]   = '0;
      end
    end else begin : g_next
      assign iden[k] = dden_q[k-1];
      assign ioor[k] = door_q[k-1];
      assign iv[k]   = dv_q[k-1];
      for (genvar c = 0; c < 3; c++) begin : g_ch
        assign irem[k][c] = drem_q[k-1][c];
        assign iq[k][c]   = dq_q[k-1][c];
      end
    end

    assign dsh = NW'(iden[k]) << B;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[k] <= 1'b0;
      else if (adv) dv_q[k] <= iv[k];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dden_q[k] <= iden[k];
        door_q[k] <= ioor[k];
        for (int c = 0; c < 3; c++) begin
          if (irem[k][c] >= dsh) begin
            drem_q[k][c] <= irem[k][c] - dsh;
            dq_q[k][c]   <= iq[k][c] | 8'(1 << B);
          end else begin
            drem_q[k][c] <= irem[k][c];
            dq_q[k][c]   <= iq[k][c];
          end
        end
      end
    end
  end

  // Last division stage is the output register.
  assign m_axis_tvalid = dv_q[NSTG-1];
  assign m_axis_tdata  = {dq_q[NSTG-1][2], dq_q[NSTG-1][1], dq_q[NSTG-1][0]};
  assign m_axis_tuser  = door_q[NSTG-1];

endmodule

/* hw/rtl/bcg_checker.sv */
// Port-level checks for the bilinear corner gradient core, bound to the top level.
`timescale 1ns / 1ps
module bcg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        pready
);

  // A pixel outside the image carries zero colour.
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("out-of-range pixel with non-zero colour");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Requests are taken whenever the output register is free or draining.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("request ready does not follow output state");

  // The configuration port never waits.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind bilinear_corner_gradient_core bcg_checker u_bcg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .pready        (pready)
);
